FILE: hdl/ecd_pkg.sv
// shared types and constants of the embedding cosine distance block
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

  localparam int ELEM_W   = 16;
  localparam int DIST_W   = 16;
  // sums hold up to 4096 squares of 2^30
  localparam int ACC_W    = 48;
  localparam int PART_W   = ACC_W / 2;
  localparam int PROD_W   = 2 * ACC_W;
  localparam int REM_W    = PROD_W + 1;
  localparam int QUOT_W   = 33;
  localparam int SQ_SRC_W = QUOT_W + 1;
  localparam int ROOT_W   = SQ_SRC_W / 2;
  localparam int SQ_REM_W = ROOT_W + 2;

  localparam int MUL_STEPS  = 8;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_W     = 6;

  localparam logic [DIST_W:0]   ONE_Q15         = 17'd32768;
  localparam logic [DIST_W-1:0] NEUTRAL_DEFAULT = 16'd16384;

  typedef enum logic [1:0] {
    RES_NEUTRAL,
    RES_ONE,
    RES_SIM
  } res_sel_t;

  typedef struct packed {
    logic     clear;
    logic     mul_init;
    logic     mul_en;
    logic     mul_src;
    logic [1:0] mul_part;
    logic     div_init;
    logic     div_step;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     load;
    res_sel_t res_sel;
  } ecd_cmd_t;

  typedef struct packed {
    logic bad_seen;
    logic track_zero;
    logic detect_zero;
    logic dot_pos;
    logic out_busy;
  } ecd_status_t;

endpackage

`default_nettype wire

FILE: hdl/ecd_item_if.sv
// input channel: one pair of embedding elements per beat
// uses ecd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ecd_item_if
  import ecd_pkg::*;
  ;
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] track_elem;
  logic signed [ELEM_W-1:0] detect_elem;
  logic                     element_bad;
  logic                     last_element;

  modport source (output valid, track_elem, detect_elem, element_bad, last_element,
                  input ready);
  modport sink (input valid, track_elem, detect_elem, element_bad, last_element,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/ecd_result_if.sv
// result channel: one distance per vector pair
// uses ecd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ecd_result_if
  import ecd_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic              used_fallback;

  modport source (output valid, distance, used_fallback, input ready);
  modport sink (input valid, distance, used_fallback, output ready);
endinterface

`default_nettype wire

FILE: hdl/ecd_cfg_if.sv
// configuration write channel for the neutral distance register
// uses ecd_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface ecd_cfg_if
  import ecd_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] neutral_distance;

  modport source (output valid, neutral_distance, input ready);
  modport sink (input valid, neutral_distance, output ready);
endinterface

`default_nettype wire

FILE: hdl/embedding_cosine_distance.sv
// Streaming cosine distance between a track and a detection embedding, Q4.12 in, Q1.15 out.
// While a vector streams in, one element pair is taken every cycle; after the pair marked
// last, input stalls until the result is in the output register. A fallback or non-positive
// dot product loads the result after the drain and decide states; otherwise it also waits on
// the 24-bit partial-product multiply, the 33-step restoring divider and the 17-step integer
// root. The next vector may stream while the result waits to be taken. MAX_LENGTH ranges
// over 1..4096.
// depends on ecd_pkg, the channel interfaces, ecd_controller and ecd_datapath
`timescale 1ns / 1ps
`default_nettype none

module embedding_cosine_distance
  import ecd_pkg::*;
#(
  parameter int MAX_LENGTH = 2048
) (
  input  logic                clk,
  input  logic                rst,
  ecd_item_if.sink            items,
  ecd_result_if.source        results,
  ecd_cfg_if.sink             cfg
);

  ecd_cmd_t    cmd;
  ecd_status_t status;
  logic        in_ready;

  assign items.ready = in_ready;
  assign cfg.ready   = 1'b1;

  ecd_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_last  (items.last_element),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  ecd_datapath #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .beat            (items.valid && in_ready),
    .track_elem      (items.track_elem),
    .detect_elem     (items.detect_elem),
    .element_bad     (items.element_bad),
    .cfg_we          (cfg.valid),
    .cfg_value       (cfg.neutral_distance),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (results.ready),
    .out_valid       (results.valid),
    .distance        (results.distance),
    .used_fallback   (results.used_fallback)
  );

endmodule

`default_nettype wire

FILE: hdl/ecd_datapath.sv
// accumulators, product sequencer, restoring divider, square root and result register
// depends on ecd_pkg; driven by ecd_controller
`timescale 1ns / 1ps
`default_nettype none

module ecd_datapath
  import ecd_pkg::*;
#(
  parameter int MAX_LENGTH = 2048
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     beat,
  input  logic signed [ELEM_W-1:0] track_elem,
  input  logic signed [ELEM_W-1:0] detect_elem,
  input  logic                     element_bad,
  input  logic                     cfg_we,
  input  logic [DIST_W-1:0]        cfg_value,
  input  ecd_cmd_t                 cmd,
  output ecd_status_t              status,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [DIST_W-1:0]        distance,
  output logic                     used_fallback
);

  localparam int CNT_W = $clog2(MAX_LENGTH + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LENGTH);
  localparam logic [ROOT_W-1:0] ROOT_MAX = ROOT_W'(2 ** (ROOT_W - 1));

  logic [DIST_W-1:0] neutral;

  // stage 1: element products
  logic signed [2*ELEM_W-1:0] td_full, tt_full, dd_full;
  logic                       s1_valid;
  logic                       s1_bad;
  logic signed [2*ELEM_W-1:0] s1_td;
  logic [2*ELEM_W-2:0]        s1_tt, s1_dd;

  // stage 2: running sums
  logic signed [ACC_W-1:0] dot_sum;
  logic [ACC_W-1:0]        track_sq, detect_sq;
  logic [CNT_W-1:0]        pair_count;
  logic                    bad_seen;

  // wide products by 24-bit partials
  logic [ACC_W-1:0]  op_a, op_b;
  logic [PART_W-1:0] half_a, half_b;
  logic [ACC_W-1:0]  pp;
  logic              pp_valid;
  logic              pp_src;
  logic [1:0]        pp_part;
  logic [PROD_W-1:0] pp_wide, pp_shifted;
  logic [PROD_W-1:0] norm_prod, dot_sq;

  // divider
  logic [REM_W-1:0]  rem, rem_sh, p_ext;
  logic              div_bit;
  logic [QUOT_W-1:0] quot;
  logic              div_ge;

  // square root
  logic [SQ_SRC_W-1:0] sq_src;
  logic [SQ_REM_W-1:0] sq_rem;
  logic [ROOT_W-1:0]   sq_root;
  logic [SQ_REM_W+1:0] sq_rem_sh, sq_trial;
  logic                sq_ge;

  logic [ROOT_W:0]   root_inc;
  logic [ROOT_W-1:0] sim_m;
  logic [DIST_W:0]   sim_dist;
  logic [DIST_W-1:0] res_value;

  assign td_full = track_elem * detect_elem;
  assign tt_full = track_elem * track_elem;
  assign dd_full = detect_elem * detect_elem;

  always_ff @(posedge clk) begin
    if (rst) begin
      neutral <= NEUTRAL_DEFAULT;
    end else if (cfg_we) begin
      neutral <= cfg_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= beat;
    end
    if (beat) begin
      s1_bad <= element_bad;
      s1_td  <= td_full;
      s1_tt  <= tt_full[2*ELEM_W-2:0];
      s1_dd  <= dd_full[2*ELEM_W-2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      dot_sum    <= '0;
      track_sq   <= '0;
      detect_sq  <= '0;
      pair_count <= '0;
      bad_seen   <= 1'b0;
    end else if (s1_valid) begin
      if (s1_bad || pair_count == MAX_CNT) begin
        bad_seen <= 1'b1;
      end else begin
        dot_sum    <= dot_sum + ACC_W'(s1_td);
        track_sq   <= track_sq + ACC_W'(s1_tt);
        detect_sq  <= detect_sq + ACC_W'(s1_dd);
        pair_count <= pair_count + 1'b1;
      end
    end
  end

  assign status.bad_seen    = bad_seen;
  assign status.track_zero  = (track_sq == '0);
  assign status.detect_zero = (detect_sq == '0);
  assign status.dot_pos     = !dot_sum[ACC_W-1] && (dot_sum != '0);
  assign status.out_busy    = out_valid;

  // dot is known positive here, so its bits read as unsigned
  assign op_a   = cmd.mul_src ? ACC_W'(unsigned'(dot_sum)) : track_sq;
  assign op_b   = cmd.mul_src ? ACC_W'(unsigned'(dot_sum)) : detect_sq;
  assign half_a = cmd.mul_part[1] ? op_a[ACC_W-1:PART_W] : op_a[PART_W-1:0];
  assign half_b = cmd.mul_part[0] ? op_b[ACC_W-1:PART_W] : op_b[PART_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
    end else begin
      pp_valid <= cmd.mul_en;
    end
    if (cmd.mul_en) begin
      pp      <= half_a * half_b;
      pp_src  <= cmd.mul_src;
      pp_part <= cmd.mul_part;
    end
  end

  assign pp_wide = PROD_W'(pp);

  always_comb begin
    case (pp_part)
      2'b00:   pp_shifted = pp_wide;
      2'b01:   pp_shifted = pp_wide << PART_W;
      2'b10:   pp_shifted = pp_wide << PART_W;
      default: pp_shifted = pp_wide << (2 * PART_W);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_init) begin
      norm_prod <= '0;
      dot_sq    <= '0;
    end else if (pp_valid) begin
      if (pp_src) begin
        dot_sq <= dot_sq + pp_shifted;
      end else begin
        norm_prod <= norm_prod + pp_shifted;
      end
    end
  end

  // quotient of dot^2 * 2^32 over the norm product; the top bits start as remainder
  assign p_ext  = REM_W'(norm_prod);
  assign rem_sh = {rem[REM_W-2:0], div_bit};
  assign div_ge = (rem_sh >= p_ext);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= REM_W'(dot_sq >> 1);
      div_bit <= dot_sq[0];
      quot    <= '0;
    end else if (cmd.div_step) begin
      rem     <= div_ge ? (rem_sh - p_ext) : rem_sh;
      div_bit <= 1'b0;
      quot    <= {quot[QUOT_W-2:0], div_ge};
    end
  end

  // integer root, two radicand bits a step
  assign sq_rem_sh = {sq_rem, sq_src[SQ_SRC_W-1 -: 2]};
  assign sq_trial  = (SQ_REM_W + 2)'({sq_root, 2'b01});
  assign sq_ge     = (sq_rem_sh >= sq_trial);

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sq_src  <= SQ_SRC_W'(quot);
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_src  <= sq_src << 2;
      sq_rem  <= sq_ge ? SQ_REM_W'(sq_rem_sh - sq_trial) : SQ_REM_W'(sq_rem_sh);
      sq_root <= {sq_root[ROOT_W-2:0], sq_ge};
    end
  end

  // largest m with 2m-1 at or below the root
  assign root_inc = (ROOT_W + 1)'(sq_root) + 1'b1;
  assign sim_m    = root_inc[ROOT_W:1];
  assign sim_dist = ONE_Q15 - (DIST_W + 1)'(sim_m);

  always_comb begin
    case (cmd.res_sel)
      RES_NEUTRAL: res_value = neutral;
      RES_ONE:     res_value = ONE_Q15[DIST_W-1:0];
      RES_SIM:     res_value = sim_dist[DIST_W-1:0];
      default:     res_value = neutral;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      distance      <= res_value;
      used_fallback <= (cmd.res_sel == RES_NEUTRAL);
    end
  end

  a_load_free : assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !out_valid)
    else $error("result loaded over an untaken result");

  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (rem < p_ext))
    else $error("divider remainder not below divisor");

  a_root_bound : assert property (@(posedge clk) disable iff (rst)
    (cmd.load && cmd.res_sel == RES_SIM) |-> (sq_root <= ROOT_MAX))
    else $error("root above full similarity");

  a_clear_idle : assert property (@(posedge clk) disable iff (rst)
    cmd.clear |-> !s1_valid)
    else $error("sums cleared with a pair in flight");

endmodule

`default_nettype wire

FILE: hdl/ecd_controller.sv
// sequencer: accumulate, decide, run products, divider and root, hand off the result
// depends on ecd_pkg; drives ecd_datapath
`timescale 1ns / 1ps
`default_nettype none

module ecd_controller
  import ecd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_last,
  output logic        in_ready,
  input  ecd_status_t status,
  output ecd_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_DECIDE,
    ST_MUL,
    ST_MUL_TAIL,
    ST_DIV_INIT,
    ST_DIV,
    ST_SQRT_INIT,
    ST_SQRT,
    ST_DONE
  } state_t;

  state_t            state;
  logic [STEP_W-1:0] step;
  res_sel_t          res_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_ACCUM;
      step    <= '0;
      res_sel <= RES_NEUTRAL;
    end else begin
      case (state)
        ST_ACCUM: begin
          if (in_valid && in_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          step <= '0;
          if (status.bad_seen || status.track_zero || status.detect_zero) begin
            res_sel <= RES_NEUTRAL;
            state   <= ST_DONE;
          end else if (!status.dot_pos) begin
            res_sel <= RES_ONE;
            state   <= ST_DONE;
          end else begin
            res_sel <= RES_SIM;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (step == STEP_W'(MUL_STEPS - 1)) begin
            step  <= '0;
            state <= ST_MUL_TAIL;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_MUL_TAIL: begin
          state <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          step  <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (step == STEP_W'(DIV_STEPS - 1)) begin
            step  <= '0;
            state <= ST_SQRT_INIT;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_SQRT_INIT: begin
          step  <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (step == STEP_W'(SQRT_STEPS - 1)) begin
            step  <= '0;
            state <= ST_DONE;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DONE: begin
          if (!status.out_busy) begin
            state <= ST_ACCUM;
          end
        end
        default: begin
          state <= ST_ACCUM;
        end
      endcase
    end
  end

  assign in_ready = (state == ST_ACCUM);

  always_comb begin
    cmd           = '0;
    cmd.res_sel   = res_sel;
    cmd.mul_init  = (state == ST_DECIDE);
    cmd.mul_en    = (state == ST_MUL);
    // norm product first, then the squared dot
    cmd.mul_src   = step[2];
    cmd.mul_part  = step[1:0];
    cmd.div_init  = (state == ST_DIV_INIT);
    cmd.div_step  = (state == ST_DIV);
    cmd.sqrt_init = (state == ST_SQRT_INIT);
    cmd.sqrt_step = (state == ST_SQRT);
    cmd.load      = (state == ST_DONE) && !status.out_busy;
    cmd.clear     = cmd.load;
  end

  a_last_stops : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_last) |=> !in_ready)
    else $error("input still open after the last pair");

endmodule

`default_nettype wire
